[rtl/core/ssi_pkg.sv]
// ----------------------------------------------------------------------------
// Sensor scaling package
// Payload types, register indexes, warning codes and the fixed-point
// constants of the linear sensor maps.
// ----------------------------------------------------------------------------
package ssi_pkg;

  // One raw plant sample.
  typedef struct packed {
    logic        overflow_raw;
    logic [14:0] level_raw;
    logic [14:0] flow_raw;
    logic [14:0] pressure_raw;
    logic [14:0] temp_raw;
    logic [15:0] saturation_raw;
    logic [14:0] pump_power_raw;
    logic [14:0] valve_flow_raw;
    logic        min_switch;
    logic        heater_on;
    logic        pump_on;
    logic        pump_mode_in;
  } ssi_in_t;

  // One scaled result with the actuator bits after the interlock.
  typedef struct packed {
    logic        overflow;
    logic [15:0] level;
    logic [13:0] flow;
    logic [15:0] pressure;
    logic [13:0] temperature;
    logic [15:0] saturation;
    logic [15:0] pump_power;
    logic [15:0] valve_flow;
    logic        heater_out;
    logic        pump_out;
    logic        pump_mode_out;
    logic [1:0]  warning;
  } ssi_out_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_TEMP_LIMIT  = 2'd0;
  localparam logic [1:0] REG_LEVEL_LIMIT = 2'd1;
  localparam logic [1:0] REG_HOLD_LIMIT  = 2'd2;

  // Register reset values.
  localparam logic [13:0] TEMP_LIMIT_RST  = 14'd3800;
  localparam logic [15:0] LEVEL_LIMIT_RST = 16'd45875;
  localparam logic [15:0] HOLD_LIMIT_RST  = 16'd10;

  // Warning codes; both bits together mean heater and pump.
  localparam logic [1:0] WARN_NONE   = 2'd0;
  localparam logic [1:0] WARN_HEATER = 2'd1;
  localparam logic [1:0] WARN_PUMP   = 2'd2;

  // Saturation limits of the result fields.
  localparam logic [15:0] MAX_16 = 16'hFFFF;
  localparam logic [15:0] MAX_14 = 16'h3FFF;

  // Width of the scaled intermediate values. The largest product is
  // below 2**61.
  localparam int unsigned MAP_W = 62;

  // Wide type for constant arithmetic at elaboration only.
  typedef logic [127:0] cwide_t;

  // Each map is floor((P -/+ Q*x) / D) with the rounding half already in P.
  // The fraction is replaced by a slope and offset scaled by 2**SH, rounded
  // so that the scaled value never falls below the exact one and exceeds it
  // by less than 1/D over the whole input range. The floor is then exact.

  // Level, on the masked reading taken in steps of 64 (common factor 2048
  // removed).
  localparam int unsigned LVL_SH = 43;
  localparam cwide_t LVL_D = 128'd14808593750;
  localparam cwide_t LVL_P = 128'd32 * 128'd952136639 * 128'd30328 + 128'd7404296875;
  localparam cwide_t LVL_Q = 128'd1843200000000;
  localparam logic [MAP_W-1:0] LVL_PA = MAP_W'(((LVL_P << LVL_SH) + LVL_D - 128'd1) / LVL_D);
  localparam logic [MAP_W-1:0] LVL_QA = MAP_W'((LVL_Q << LVL_SH) / LVL_D);

  // Flow.
  localparam int unsigned FLW_SH = 42;
  localparam cwide_t FLW_D = 128'd105390000;
  localparam cwide_t FLW_P = 128'd102578992 * 128'd10539 + 128'd52695000;
  localparam cwide_t FLW_Q = 128'd33000000;
  localparam logic [MAP_W-1:0] FLW_PA = MAP_W'(((FLW_P << FLW_SH) + FLW_D - 128'd1) / FLW_D);
  localparam logic [MAP_W-1:0] FLW_QA = MAP_W'((FLW_Q << FLW_SH) / FLW_D);

  // Pressure (common factor 24000 removed).
  localparam int unsigned PRS_SH = 41;
  localparam cwide_t PRS_D = 128'd49225000;
  localparam cwide_t PRS_P = 128'd997328593 * 128'd1969 + 128'd24612500;
  localparam cwide_t PRS_Q = 128'd60000000;
  localparam logic [MAP_W-1:0] PRS_PA = MAP_W'(((PRS_P << PRS_SH) + PRS_D - 128'd1) / PRS_D);
  localparam logic [MAP_W-1:0] PRS_QA = MAP_W'((PRS_Q << PRS_SH) / PRS_D);

  // Temperature.
  localparam int unsigned TMP_SH = 40;
  localparam cwide_t TMP_D = 128'd23850000;
  localparam cwide_t TMP_P = 128'd116630189 * 128'd2385 + 128'd11925000;
  localparam cwide_t TMP_Q = 128'd9000000;
  localparam logic [MAP_W-1:0] TMP_PA = MAP_W'(((TMP_P << TMP_SH) + TMP_D - 128'd1) / TMP_D);
  localparam logic [MAP_W-1:0] TMP_QA = MAP_W'((TMP_Q << TMP_SH) / TMP_D);

  // Pump power and valve flow, an increasing map with a negative offset
  // (common factor 4096 removed).
  localparam int unsigned PCT_SH = 45;
  localparam cwide_t PCT_D = 128'd625781250;
  localparam cwide_t PCT_K = 128'd16 * 128'd6398252 * 128'd25632 - 128'd312890625;
  localparam cwide_t PCT_Q = 128'd800000000;
  localparam logic [MAP_W-1:0] PCT_QA = MAP_W'(((PCT_Q << PCT_SH) + PCT_D - 128'd1) / PCT_D);
  localparam logic [MAP_W-1:0] PCT_KA = MAP_W'((PCT_K << PCT_SH) / PCT_D);

  // Decreasing map: floor((pa - qa*x) / 2**sh), clamped to [0, maxv].
  function automatic logic [15:0] down_map(input logic [MAP_W-1:0] pa,
                                           input logic [MAP_W-1:0] qa,
                                           input logic [14:0] x,
                                           input int unsigned sh,
                                           input logic [15:0] maxv);
    logic [MAP_W-1:0] prod;
    logic [MAP_W-1:0] quo;
    logic [15:0]      res;
    prod = qa * MAP_W'(x);
    quo  = (pa - prod) >> sh;
    if (prod > pa) begin
      res = '0;
    end else if (quo > MAP_W'(maxv)) begin
      res = maxv;
    end else begin
      res = quo[15:0];
    end
    return res;
  endfunction

  // Increasing map: floor((qa*x - ka) / 2**sh), clamped to [0, maxv].
  function automatic logic [15:0] up_map(input logic [MAP_W-1:0] qa,
                                         input logic [MAP_W-1:0] ka,
                                         input logic [14:0] x,
                                         input int unsigned sh,
                                         input logic [15:0] maxv);
    logic [MAP_W-1:0] prod;
    logic [MAP_W-1:0] quo;
    logic [15:0]      res;
    prod = qa * MAP_W'(x);
    quo  = (prod - ka) >> sh;
    if (prod < ka) begin
      res = '0;
    end else if (quo > MAP_W'(maxv)) begin
      res = maxv;
    end else begin
      res = quo[15:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/sensor_scaling_with_interlock.sv]
// ----------------------------------------------------------------------------
// Sensor scaling with interlock
// Scales one raw plant sample per transfer into fixed-point units, applies
// the heater and pump safety interlock and holds the warning code.
// ----------------------------------------------------------------------------
// An accepted sample passes through the input register and then the result
// register. One sample per cycle while results are taken; a waiting result
// lets one more sample into the input register and then stalls the input.
// Reset (synchronous, rst_n low): both stages empty, hold counter and held
// warning cleared, limits back to 3800, 45875 and 10.
module sensor_scaling_with_interlock
  import ssi_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Raw sample input
  input  logic        in_valid,
  output logic        in_stall,
  input  ssi_in_t     in_data,
  // Result output
  output logic        out_valid,
  input  logic        out_stall,
  output ssi_out_t    out_data,
  // Configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Configuration registers.
  logic [13:0] temp_limit_r;
  logic [15:0] level_limit_r;
  logic [15:0] hold_limit_r;

  // Warning hold state.
  logic [15:0] hold_count_r;
  logic [15:0] hold_count_nxt;
  logic [1:0]  held_warning_r;
  logic [1:0]  held_warning_nxt;

  // Pipeline registers.
  logic        s1_valid_r;
  ssi_in_t     s1_data_r;
  logic        out_valid_r;
  ssi_out_t    out_data_r;
  ssi_out_t    res_nxt;

  logic        in_xfer;
  logic        advance;
  logic        move;

  // Scaled values and interlock terms.
  logic [15:0] temp_full;
  logic [15:0] flow_full;
  logic        trip;
  logic        heater_cut;
  logic        pump_cut;
  logic [1:0]  code;
  logic        keep_held;

  // Handshake: the input register drains whenever the result register is
  // free or its transfer completes.
  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_xfer   = in_valid && !in_stall;
  assign move      = advance && s1_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Linear maps and the interlock on the registered sample.
  always_comb begin
    res_nxt = '0;

    flow_full = down_map(FLW_PA, FLW_QA, s1_data_r.flow_raw, FLW_SH, MAX_14);
    temp_full = down_map(TMP_PA, TMP_QA, s1_data_r.temp_raw, TMP_SH, MAX_14);

    res_nxt.overflow    = ~s1_data_r.overflow_raw;
    res_nxt.level       = down_map(LVL_PA, LVL_QA, {6'd0, s1_data_r.level_raw[14:6]},
                                   LVL_SH, MAX_16);
    res_nxt.flow        = flow_full[13:0];
    res_nxt.pressure    = down_map(PRS_PA, PRS_QA, s1_data_r.pressure_raw, PRS_SH, MAX_16);
    res_nxt.temperature = temp_full[13:0];
    res_nxt.saturation  = s1_data_r.saturation_raw;
    res_nxt.pump_power  = up_map(PCT_QA, PCT_KA, s1_data_r.pump_power_raw, PCT_SH, MAX_16);
    res_nxt.valve_flow  = up_map(PCT_QA, PCT_KA, s1_data_r.valve_flow_raw, PCT_SH, MAX_16);

    // Heater is cut on a low minimum switch or an over-limit reading; the
    // pump only on a low minimum switch.
    trip       = !s1_data_r.min_switch || (res_nxt.temperature > temp_limit_r) ||
                 (res_nxt.level > level_limit_r);
    heater_cut = trip && s1_data_r.heater_on;
    pump_cut   = !s1_data_r.min_switch && s1_data_r.pump_on;
    code       = (heater_cut ? WARN_HEATER : WARN_NONE) | (pump_cut ? WARN_PUMP : WARN_NONE);

    res_nxt.heater_out    = s1_data_r.heater_on && !heater_cut;
    res_nxt.pump_out      = s1_data_r.pump_on && !pump_cut;
    res_nxt.pump_mode_out = s1_data_r.pump_mode_in && !pump_cut;

    // Warning hold: a running hold keeps its code while no other code shows.
    keep_held = ((code == WARN_NONE) || (code == held_warning_r)) &&
                (hold_count_r != 16'd0) && (hold_count_r < hold_limit_r);
    if (keep_held) begin
      hold_count_nxt   = hold_count_r + 16'd1;
      held_warning_nxt = held_warning_r;
      res_nxt.warning  = held_warning_r;
    end else if (code != WARN_NONE) begin
      hold_count_nxt   = 16'd1;
      held_warning_nxt = code;
      res_nxt.warning  = code;
    end else begin
      hold_count_nxt   = 16'd0;
      held_warning_nxt = WARN_NONE;
      res_nxt.warning  = WARN_NONE;
    end
  end

  // Control state, hold state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      hold_count_r   <= 16'd0;
      held_warning_r <= WARN_NONE;
      temp_limit_r   <= TEMP_LIMIT_RST;
      level_limit_r  <= LEVEL_LIMIT_RST;
      hold_limit_r   <= HOLD_LIMIT_RST;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
      end
      if (move) begin
        hold_count_r   <= hold_count_nxt;
        held_warning_r <= held_warning_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_TEMP_LIMIT:  temp_limit_r  <= cfg_data[13:0];
          REG_LEVEL_LIMIT: level_limit_r <= cfg_data;
          REG_HOLD_LIMIT:  hold_limit_r  <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_data_r <= in_data;
    end
    if (move) begin
      out_data_r <= res_nxt;
    end
  end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// Sensor scaling with interlock testbench
// Drives raw plant samples through the block with random bursts, gaps and
// output stalls, predicts every scaled result, the interlock and the held
// warning code, and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ssi_pkg::*;

  // Numerators and denominators of the exact sensor maps, all scaled to
  // integers so that rounding can be done in 64-bit arithmetic.
  localparam longint LEVEL_OFS  = 64'sd65536 * 64'sd952136639 * 64'sd30328;
  localparam longint LEVEL_STEP = 64'sd65536 * 64'sd900000000;
  localparam longint LEVEL_DIV  = 64'sd30328000000000;
  localparam longint FLOW_OFS   = 64'sd102578992 * 64'sd10539;
  localparam longint FLOW_STEP  = 64'sd33000000;
  localparam longint FLOW_DIV   = 64'sd105390000;
  localparam longint PRES_OFS   = 64'sd4000 * 64'sd997328593 * 64'sd11814;
  localparam longint PRES_STEP  = 64'sd1440000000000;
  localparam longint PRES_DIV   = 64'sd1181400000000;
  localparam longint TEMP_OFS   = 64'sd116630189 * 64'sd2385;
  localparam longint TEMP_STEP  = 64'sd9000000;
  localparam longint TEMP_DIV   = 64'sd23850000;
  localparam longint FRAC_STEP  = 64'sd3276800000000;
  localparam longint FRAC_OFS   = 64'sd65536 * 64'sd6398252 * 64'sd25632;
  localparam longint FRAC_DIV   = 64'sd2563200000000;

  localparam logic [14:0] LEVEL_KEEP = 15'h7FC0;
  localparam int MAX_REPORTS = 10;

  // Expected scaled results and the interlock state that produces them.
  class scaled_result_board;
    logic [13:0] temp_limit;
    logic [15:0] level_limit;
    logic [15:0] hold_limit;
    int unsigned hold_count;
    logic [1:0]  held_warning;
    ssi_out_t    pending[$];
    int          errors;

    function new();
      temp_limit   = TEMP_LIMIT_RST;
      level_limit  = LEVEL_LIMIT_RST;
      hold_limit   = HOLD_LIMIT_RST;
      hold_count   = 0;
      held_warning = WARN_NONE;
      errors       = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [15:0] value);
      case (idx)
        REG_TEMP_LIMIT:  temp_limit  = value[13:0];
        REG_LEVEL_LIMIT: level_limit = value;
        REG_HOLD_LIMIT:  hold_limit  = value;
        default: ;
      endcase
    endfunction

    // Round half up, clamp negatives to zero and saturate at the top.
    static function longint round_clamp(longint num, longint den, longint maxv);
      longint q;
      if (num <= 0) begin
        return 0;
      end
      q = (num + den / 2) / den;
      return (q > maxv) ? maxv : q;
    endfunction

    function void report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t ERROR: %s", $time, msg);
      end
    endfunction

    // Work out the result of one accepted sample and queue it.
    function void note_sample(ssi_in_t s);
      ssi_out_t   e;
      logic [1:0] code;
      logic       trip;
      e = '0;
      e.overflow = ~s.overflow_raw;
      e.level = 16'(round_clamp(LEVEL_OFS - LEVEL_STEP * longint'(s.level_raw & LEVEL_KEEP),
                                LEVEL_DIV, longint'(MAX_16)));
      e.flow = 14'(round_clamp(FLOW_OFS - FLOW_STEP * longint'(s.flow_raw),
                               FLOW_DIV, longint'(MAX_14)));
      e.pressure = 16'(round_clamp(PRES_OFS - PRES_STEP * longint'(s.pressure_raw),
                                   PRES_DIV, longint'(MAX_16)));
      e.temperature = 14'(round_clamp(TEMP_OFS - TEMP_STEP * longint'(s.temp_raw),
                                      TEMP_DIV, longint'(MAX_14)));
      e.saturation = s.saturation_raw;
      e.pump_power = 16'(round_clamp(FRAC_STEP * longint'(s.pump_power_raw) - FRAC_OFS,
                                     FRAC_DIV, longint'(MAX_16)));
      e.valve_flow = 16'(round_clamp(FRAC_STEP * longint'(s.valve_flow_raw) - FRAC_OFS,
                                     FRAC_DIV, longint'(MAX_16)));
      e.heater_out    = s.heater_on;
      e.pump_out      = s.pump_on;
      e.pump_mode_out = s.pump_mode_in;

      // Interlock on the scaled values.
      code = WARN_NONE;
      trip = !s.min_switch || (e.temperature > temp_limit) || (e.level > level_limit);
      if (trip) begin
        if (s.heater_on) begin
          e.heater_out = 1'b0;
          code = WARN_HEATER;
        end
        if (!s.min_switch && s.pump_on) begin
          e.pump_out      = 1'b0;
          e.pump_mode_out = 1'b0;
          code = code | WARN_PUMP;
        end
      end

      // Warning hold.
      if ((code == WARN_NONE || code == held_warning) && hold_count > 0 &&
          hold_count < hold_limit) begin
        hold_count++;
        e.warning = held_warning;
      end else if (code != WARN_NONE) begin
        hold_count   = 1;
        held_warning = code;
        e.warning    = code;
      end else begin
        hold_count   = 0;
        held_warning = WARN_NONE;
        e.warning    = WARN_NONE;
      end
      pending.push_back(e);
    endfunction

    // Compare one result transfer with the oldest expectation.
    function void check_result(ssi_out_t got);
      ssi_out_t e;
      string    d;
      if (pending.size() == 0) begin
        report($sformatf("result with nothing expected: %h", got));
        return;
      end
      e = pending.pop_front();
      d = "";
      if (e.overflow != got.overflow)
        d = {d, $sformatf(" overflow %0d/%0d", e.overflow, got.overflow)};
      if (e.level != got.level)
        d = {d, $sformatf(" level %0d/%0d", e.level, got.level)};
      if (e.flow != got.flow)
        d = {d, $sformatf(" flow %0d/%0d", e.flow, got.flow)};
      if (e.pressure != got.pressure)
        d = {d, $sformatf(" pressure %0d/%0d", e.pressure, got.pressure)};
      if (e.temperature != got.temperature)
        d = {d, $sformatf(" temperature %0d/%0d", e.temperature, got.temperature)};
      if (e.saturation != got.saturation)
        d = {d, $sformatf(" saturation %0d/%0d", e.saturation, got.saturation)};
      if (e.pump_power != got.pump_power)
        d = {d, $sformatf(" pump_power %0d/%0d", e.pump_power, got.pump_power)};
      if (e.valve_flow != got.valve_flow)
        d = {d, $sformatf(" valve_flow %0d/%0d", e.valve_flow, got.valve_flow)};
      if (e.heater_out != got.heater_out)
        d = {d, $sformatf(" heater_out %0d/%0d", e.heater_out, got.heater_out)};
      if (e.pump_out != got.pump_out)
        d = {d, $sformatf(" pump_out %0d/%0d", e.pump_out, got.pump_out)};
      if (e.pump_mode_out != got.pump_mode_out)
        d = {d, $sformatf(" pump_mode_out %0d/%0d", e.pump_mode_out, got.pump_mode_out)};
      if (e.warning != got.warning)
        d = {d, $sformatf(" warning %0d/%0d", e.warning, got.warning)};
      if (d != "") begin
        report({"result mismatch (expected/actual):", d});
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  ssi_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  ssi_out_t    out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_TEMP_LIMIT;
  logic [15:0] cfg_data = '0;

  scaled_result_board board = new();

  // Receiver hold-off requests and stall pattern state.
  int hold_offs_asked = 0;
  int hold_offs_done  = 0;
  int hold_left       = 0;
  int stall_style     = 0;
  int style_left      = 0;
  int stall_tick      = 0;

  sensor_scaling_with_interlock i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Watch every transfer and register write at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        board.check_result(out_data);
      end
      if (in_valid && !in_stall) begin
        board.note_sample(in_data);
      end
      if (cfg_we) begin
        board.write_reg(cfg_index, cfg_data);
      end
    end
  end

  // Receiver stall: long hold-offs on request, otherwise a pattern that
  // changes style every so often, including stretches with no stall.
  always begin
    @(negedge clk);
    stall_tick++;
    if (hold_left == 0 && hold_offs_asked != hold_offs_done) begin
      hold_offs_done++;
      hold_left = $urandom_range(40, 80);
    end
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(20, 200);
    end
    style_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((stall_tick % 7) < 3);
      endcase
    end
  end

  // Offer one sample and hold it until the transfer.
  task automatic send_sample(ssi_in_t s);
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    do begin
      @(posedge clk);
    end while (in_stall);
  endtask

  // Leave the input idle with random junk on the data lines.
  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_data  <= ssi_in_t'({$urandom, $urandom, $urandom, $urandom});
    end
  endtask

  // Stop offering and wait until every expected result has arrived.
  task automatic drain();
    idle_cycles(1);
    while (board.pending.size() != 0) begin
      @(posedge clk);
    end
    idle_cycles(3);
  endtask

  task automatic program_reg(logic [1:0] idx, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random sample, biased toward the temperature and level cutoffs and
  // toward running actuators so that the interlock has work to do.
  function automatic ssi_in_t random_sample();
    ssi_in_t s;
    s = ssi_in_t'({$urandom, $urandom, $urandom, $urandom});
    case ($urandom_range(0, 3))
      0: s.temp_raw = 15'($urandom_range(20537, 21137));
      1: s.temp_raw = 15'($urandom_range(15000, 26000));
      default: ;
    endcase
    case ($urandom_range(0, 3))
      0: s.level_raw = 15'($urandom_range(8000, 9000));
      1: s.level_raw = 15'($urandom_range(4000, 14000));
      default: ;
    endcase
    if ($urandom_range(0, 15) == 0) s.flow_raw = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 15) == 0) s.pump_power_raw = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 15) == 0) s.saturation_raw = $urandom_range(0, 1) ? '1 : '0;
    s.min_switch = ($urandom_range(0, 4) != 0);
    s.heater_on  = ($urandom_range(0, 3) != 0);
    s.pump_on    = ($urandom_range(0, 3) != 0);
    return s;
  endfunction

  task automatic run_random(int count, bit with_hold_off);
    int sent;
    int burst;
    sent = 0;
    while (sent < count) begin
      // Ask for a long receiver hold-off partway through, while the
      // sender keeps offering samples.
      if (with_hold_off && sent >= count / 3) begin
        hold_offs_asked++;
        with_hold_off = 1'b0;
      end
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 16);
      repeat (burst) begin
        send_sample(random_sample());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) begin
        idle_cycles($urandom_range(1, 6));
      end
    end
  endtask

  // Extremes, each interlock case, the cutoff boundaries and level masking.
  task automatic run_directed();
    ssi_in_t nominal;
    ssi_in_t s;
    int      lv[5];
    lv = '{8000, 8447, 8448, 8511, 8512};
    nominal = '0;
    nominal.overflow_raw   = 1'b1;
    nominal.level_raw      = 15'd16000;
    nominal.flow_raw       = 15'd12000;
    nominal.pressure_raw   = 15'd20000;
    nominal.temp_raw       = 15'd25000;
    nominal.saturation_raw = 16'd5000;
    nominal.pump_power_raw = 15'd16000;
    nominal.valve_flow_raw = 15'd3000;
    nominal.min_switch     = 1'b1;
    nominal.heater_on      = 1'b1;
    nominal.pump_on        = 1'b1;
    nominal.pump_mode_in   = 1'b1;

    send_sample('0);
    send_sample('1);
    send_sample(nominal);
    s = nominal;
    s.temp_raw = 15'd20000;
    send_sample(s);
    idle_cycles(2);
    // Temperature right around the reset cutoff.
    for (int x = 20835; x <= 20839; x++) begin
      s = nominal;
      s.temp_raw = 15'(x);
      send_sample(s);
    end
    // Level around its cutoff; the low six bits do not count.
    foreach (lv[i]) begin
      s = nominal;
      s.level_raw = 15'(lv[i]);
      send_sample(s);
    end
    idle_cycles(1);
    // Low minimum switch with the pump alone, both actuators and neither on.
    s = nominal;
    s.min_switch = 1'b0;
    s.heater_on  = 1'b0;
    send_sample(s);
    s = nominal;
    s.min_switch = 1'b0;
    send_sample(s);
    s.heater_on = 1'b0;
    s.pump_on   = 1'b0;
    send_sample(s);
    // Trip with the heater already off.
    s = nominal;
    s.temp_raw  = 15'd20000;
    s.heater_on = 1'b0;
    send_sample(s);
    s = nominal;
    s.overflow_raw   = 1'b0;
    s.saturation_raw = '1;
    s.pump_power_raw = '1;
    s.valve_flow_raw = '0;
    send_sample(s);
    send_sample(nominal);
  endtask

  initial begin : stimulus
    logic [15:0] t_lim;
    logic [15:0] l_lim;
    logic [15:0] h_lim;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    run_directed();
    run_random(160, 1'b1);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          t_lim = 16'd0;
          l_lim = 16'd0;
          h_lim = 16'd1;
        end
        1: begin
          // Top bits above the temperature limit width are dropped.
          t_lim = 16'hFFFF;
          l_lim = 16'hFFFF;
          h_lim = 16'd0;
        end
        2: begin
          t_lim = 16'd3800;
          l_lim = 16'd45875;
          h_lim = 16'hFFFF;
        end
        default: begin
          t_lim = 16'($urandom_range(2000, 6000));
          l_lim = 16'($urandom_range(30000, 60000));
          h_lim = 16'($urandom_range(1, 20));
        end
      endcase
      program_reg(REG_TEMP_LIMIT, t_lim);
      program_reg(REG_LEVEL_LIMIT, l_lim);
      program_reg(REG_HOLD_LIMIT, h_lim);
      run_random(160, phase == 2);
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.pending.size() != 0) begin
      board.report($sformatf("%0d results never arrived", board.pending.size()));
    end
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin : watchdog
    #3000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[sensor_scaling_with_interlock.f]
rtl/core/ssi_pkg.sv
rtl/core/sensor_scaling_with_interlock.sv
dv/testbench.sv
